// ===== rtl/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// Silhouette edge extrusion package
// Shared types, register indexes, reset values, corner codes and the saturation helper.
// ----------------------------------------------------------------------------
package sed_pkg;

   typedef logic [31:0]            word_type;
   typedef logic [2:0][31:0]       vec3_type;
   typedef logic [3:0][2:0][31:0]  quad_type;
   typedef logic [1:0]             corner_type;
   typedef logic [1:0]             reg_index_type;

   typedef struct packed {
      logic [31:0] light_x;
      logic [31:0] light_y;
      logic [31:0] light_z;
      logic [30:0] extrude_length;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic silhouette;
   } pipe_ctl_type;

   localparam reg_index_type REG_LIGHT_X        = 2'd0;
   localparam reg_index_type REG_LIGHT_Y        = 2'd1;
   localparam reg_index_type REG_LIGHT_Z        = 2'd2;
   localparam reg_index_type REG_EXTRUDE_LENGTH = 2'd3;

   localparam logic [31:0] LIGHT_X_RESET        = 32'd327680;
   localparam logic [31:0] LIGHT_Y_RESET        = 32'd327680;
   localparam logic [31:0] LIGHT_Z_RESET        = 32'd0;
   localparam logic [30:0] EXTRUDE_LENGTH_RESET = 31'd655360;

   localparam corner_type CORNER_START     = 2'd0;
   localparam corner_type CORNER_END       = 2'd1;
   localparam corner_type CORNER_EXT_END   = 2'd2;
   localparam corner_type CORNER_EXT_START = 2'd3;

   localparam logic signed [49:0] SAT_HI = 50'sd2147483647;
   localparam logic signed [49:0] SAT_LO = -50'sd2147483648;

   function automatic logic [31:0] sed_sat32(input logic signed [49:0] v);
      logic [31:0] r;
      if (v > SAT_HI) begin
         r = 32'h7fff_ffff;
      end else if (v < SAT_LO) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/sed_pipe.sv =====
// ----------------------------------------------------------------------------
// Silhouette edge extrusion arithmetic pipeline
// Three register stages: light differences, products, sums with facing test
// and saturated extrusion. A full stage holds while the stage after it cannot take it.
// ----------------------------------------------------------------------------
module sed_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  sed_pkg::cfg_type      cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sed_pkg::vec3_type     in_start,
   input  sed_pkg::vec3_type     in_end,
   input  sed_pkg::vec3_type     in_na,
   input  sed_pkg::vec3_type     in_nb,
   output sed_pkg::pipe_ctl_type out_ctl,
   output sed_pkg::quad_type     out_quad,
   input  logic                  out_ready
);
   import sed_pkg::*;

   vec3_type             light;
   logic signed [31:0]   len_s;

   logic                 s1_valid_ff;
   logic                 s2_valid_ff;
   logic                 s3_valid_ff;
   logic                 s1_ready;
   logic                 s2_ready;
   logic                 s3_ready;

   vec3_type             s1_start_ff;
   vec3_type             s1_end_ff;
   vec3_type             s1_na_ff;
   vec3_type             s1_nb_ff;
   logic signed [32:0]   s1_ds_in [3];
   logic signed [32:0]   s1_ds_ff [3];
   logic signed [32:0]   s1_de_in [3];
   logic signed [32:0]   s1_de_ff [3];

   vec3_type             s2_start_ff;
   vec3_type             s2_end_ff;
   logic signed [64:0]   s2_pa_in [3];
   logic signed [64:0]   s2_pa_ff [3];
   logic signed [64:0]   s2_pb_in [3];
   logic signed [64:0]   s2_pb_ff [3];
   logic signed [64:0]   s2_xs_in [3];
   logic signed [64:0]   s2_xs_ff [3];
   logic signed [64:0]   s2_xe_in [3];
   logic signed [64:0]   s2_xe_ff [3];

   vec3_type             s3_start_ff;
   vec3_type             s3_end_ff;
   logic signed [66:0]   s3_suma_in;
   logic signed [66:0]   s3_suma_ff;
   logic signed [66:0]   s3_sumb_in;
   logic signed [66:0]   s3_sumb_ff;
   vec3_type             s3_xs_in;
   vec3_type             s3_xs_ff;
   vec3_type             s3_xe_in;
   vec3_type             s3_xe_ff;

   logic                 front_a;
   logic                 front_b;

   assign light = {cfg.light_z, cfg.light_y, cfg.light_x};
   assign len_s = $signed({1'b0, cfg.extrude_length});

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_ds_in[i] = $signed({in_start[i][31], in_start[i]})
                     - $signed({light[i][31], light[i]});
         s1_de_in[i] = $signed({in_end[i][31], in_end[i]})
                     - $signed({light[i][31], light[i]});
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_pa_in[i] = s1_ds_ff[i] * $signed(s1_na_ff[i]);
         s2_pb_in[i] = s1_ds_ff[i] * $signed(s1_nb_ff[i]);
         s2_xs_in[i] = s1_ds_ff[i] * len_s;
         s2_xe_in[i] = s1_de_ff[i] * len_s;
      end
   end

   always_comb begin
      s3_suma_in = 67'(s2_pa_ff[0]) + 67'(s2_pa_ff[1]) + 67'(s2_pa_ff[2]);
      s3_sumb_in = 67'(s2_pb_ff[0]) + 67'(s2_pb_ff[1]) + 67'(s2_pb_ff[2]);
      for (int i = 0; i < 3; i++) begin
         s3_xs_in[i] = sed_sat32(50'($signed(s2_start_ff[i]))
                               + 50'($signed(s2_xs_ff[i][64:16])));
         s3_xe_in[i] = sed_sat32(50'($signed(s2_end_ff[i]))
                               + 50'($signed(s2_xe_ff[i][64:16])));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_start_ff <= in_start;
         s1_end_ff   <= in_end;
         s1_na_ff    <= in_na;
         s1_nb_ff    <= in_nb;
         s1_ds_ff    <= s1_ds_in;
         s1_de_ff    <= s1_de_in;
      end
      if (s2_ready) begin
         s2_start_ff <= s1_start_ff;
         s2_end_ff   <= s1_end_ff;
         s2_pa_ff    <= s2_pa_in;
         s2_pb_ff    <= s2_pb_in;
         s2_xs_ff    <= s2_xs_in;
         s2_xe_ff    <= s2_xe_in;
      end
      if (s3_ready) begin
         s3_start_ff <= s2_start_ff;
         s3_end_ff   <= s2_end_ff;
         s3_suma_ff  <= s3_suma_in;
         s3_sumb_ff  <= s3_sumb_in;
         s3_xs_ff    <= s3_xs_in;
         s3_xe_ff    <= s3_xe_in;
      end
   end

   assign front_a = !s3_suma_ff[66] && (s3_suma_ff != '0);
   assign front_b = !s3_sumb_ff[66] && (s3_sumb_ff != '0);

   always_comb begin
      out_ctl.valid      = s3_valid_ff;
      out_ctl.silhouette = front_a ^ front_b;
      if (front_a) begin
         out_quad = {s3_xs_ff, s3_xe_ff, s3_end_ff, s3_start_ff};
      end else begin
         out_quad = {s3_xe_ff, s3_xs_ff, s3_start_ff, s3_end_ff};
      end
   end

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff))
      else $error("input blocked while the pipeline has a free stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && !out_ready) |=>
         (s3_valid_ff && $stable(s3_suma_ff) && $stable(s3_sumb_ff)
          && $stable(s3_xs_ff) && $stable(s3_xe_ff)))
      else $error("last stage changed while stalled");

endmodule

// ===== rtl/sed_quad_out.sv =====
// ----------------------------------------------------------------------------
// Silhouette edge extrusion quad output
// Holds one quad and sends its four vertices in corner order, one per
// transfer. Edges that are not silhouettes are dropped here.
// ----------------------------------------------------------------------------
module sed_quad_out (
   input  logic                  clock,
   input  logic                  reset,
   input  sed_pkg::pipe_ctl_type in_ctl,
   input  sed_pkg::quad_type     in_quad,
   output logic                  in_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sed_pkg::vec3_type     rsp_vertex,
   output sed_pkg::corner_type   rsp_corner,
   output logic                  rsp_last_vertex
);
   import sed_pkg::*;

   logic       q_valid_ff;
   corner_type corner_ff;
   quad_type   vert_ff;
   logic       last;
   logic       q_free;
   logic       load;
   logic       take;

   assign last     = (corner_ff == CORNER_EXT_START);
   assign take     = q_valid_ff && rsp_ready;
   assign q_free   = !q_valid_ff || (rsp_ready && last);
   assign in_ready = !in_ctl.silhouette || q_free;
   assign load     = in_ctl.valid && in_ctl.silhouette && q_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         corner_ff  <= CORNER_START;
      end else if (load) begin
         q_valid_ff <= 1'b1;
         corner_ff  <= CORNER_START;
      end else if (take) begin
         if (last) begin
            q_valid_ff <= 1'b0;
         end else begin
            corner_ff <= corner_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vert_ff <= in_quad;
      end else if (take) begin
         vert_ff <= {vert_ff[3], vert_ff[3], vert_ff[2], vert_ff[1]};
      end
   end

   assign rsp_valid       = q_valid_ff;
   assign rsp_vertex      = vert_ff[0];
   assign rsp_corner      = corner_ff;
   assign rsp_last_vertex = last;

   a_corner_steps: assert property (@(posedge clock) disable iff (reset)
      (q_valid_ff && rsp_ready && !last) |=>
         (q_valid_ff && corner_ff == $past(corner_ff) + 2'd1))
      else $error("corner did not advance after a transfer");

   a_quad_starts: assert property (@(posedge clock) disable iff (reset)
      (in_ctl.valid && in_ctl.silhouette && in_ready) |=>
         (q_valid_ff && corner_ff == CORNER_START))
      else $error("new quad did not start at its first corner");

endmodule

// ===== rtl/silhouette_edge_extrude_core.sv =====
// ----------------------------------------------------------------------------
// Silhouette edge extrusion core
// Each transfer on the req_ channel is one edge shared by two faces: its
// endpoints as face A lists them and both face normals, signed Q16.16. The
// block tests which faces look toward the light. When exactly one does, four
// shadow-volume quad vertices leave on the rsp_ channel in corner order:
// start, end, extruded end, extruded start, with last_vertex on the fourth.
// Other edges give no transfer. The csr_ port holds the light position and
// the extrusion length; write it only while the block is idle.
// An edge passes through three arithmetic stages and the quad output register
// before its first vertex can transfer. An edge enters every cycle while
// req_ready is high, and the output register sends one vertex per cycle while
// rsp_ready is high. When rsp_ready is low the quad holds and the three stages
// fill behind it, then req_ready drops. Reset empties every stage and loads the
// register defaults.
// ----------------------------------------------------------------------------
module silhouette_edge_extrude_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_end_x,
   input  logic signed [31:0] req_end_y,
   input  logic signed [31:0] req_end_z,
   input  logic signed [31:0] req_normal_a_x,
   input  logic signed [31:0] req_normal_a_y,
   input  logic signed [31:0] req_normal_a_z,
   input  logic signed [31:0] req_normal_b_x,
   input  logic signed [31:0] req_normal_b_y,
   input  logic signed [31:0] req_normal_b_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic signed [31:0] rsp_vertex_z,
   output logic [1:0]         rsp_corner,
   output logic               rsp_last_vertex,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import sed_pkg::*;

   logic [31:0]   light_x_reg_ff;
   logic [31:0]   light_y_reg_ff;
   logic [31:0]   light_z_reg_ff;
   logic [30:0]   length_reg_ff;
   reg_index_type csr_index;
   logic          csr_write;
   cfg_type       cfg;

   vec3_type      req_start;
   vec3_type      req_end;
   vec3_type      req_na;
   vec3_type      req_nb;
   pipe_ctl_type  pipe_ctl;
   quad_type      pipe_quad;
   logic          pipe_ready;
   vec3_type      rsp_vertex;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_reg_ff <= LIGHT_X_RESET;
         light_y_reg_ff <= LIGHT_Y_RESET;
         light_z_reg_ff <= LIGHT_Z_RESET;
         length_reg_ff  <= EXTRUDE_LENGTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_LIGHT_X: begin
               light_x_reg_ff <= csr_pwdata;
            end
            REG_LIGHT_Y: begin
               light_y_reg_ff <= csr_pwdata;
            end
            REG_LIGHT_Z: begin
               light_z_reg_ff <= csr_pwdata;
            end
            REG_EXTRUDE_LENGTH: begin
               length_reg_ff <= csr_pwdata[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_LIGHT_X:        csr_prdata = light_x_reg_ff;
         REG_LIGHT_Y:        csr_prdata = light_y_reg_ff;
         REG_LIGHT_Z:        csr_prdata = light_z_reg_ff;
         REG_EXTRUDE_LENGTH: csr_prdata = {1'b0, length_reg_ff};
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.light_x        = light_x_reg_ff;
   assign cfg.light_y        = light_y_reg_ff;
   assign cfg.light_z        = light_z_reg_ff;
   assign cfg.extrude_length = length_reg_ff;

   assign req_start = {req_start_z, req_start_y, req_start_x};
   assign req_end   = {req_end_z, req_end_y, req_end_x};
   assign req_na    = {req_normal_a_z, req_normal_a_y, req_normal_a_x};
   assign req_nb    = {req_normal_b_z, req_normal_b_y, req_normal_b_x};

   sed_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_start  (req_start),
      .in_end    (req_end),
      .in_na     (req_na),
      .in_nb     (req_nb),
      .out_ctl   (pipe_ctl),
      .out_quad  (pipe_quad),
      .out_ready (pipe_ready)
   );

   sed_quad_out u_quad_out (
      .clock           (clock),
      .reset           (reset),
      .in_ctl          (pipe_ctl),
      .in_quad         (pipe_quad),
      .in_ready        (pipe_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex      (rsp_vertex),
      .rsp_corner      (rsp_corner),
      .rsp_last_vertex (rsp_last_vertex)
   );

   assign rsp_vertex_x = $signed(rsp_vertex[0]);
   assign rsp_vertex_y = $signed(rsp_vertex[1]);
   assign rsp_vertex_z = $signed(rsp_vertex[2]);

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Silhouette edge extrusion testbench
// Drives edges on the request channel and checks every quad vertex on the
// response channel against a bit-exact predictor of the facing test and the
// saturated extrusion. The light position and extrusion length are reloaded
// through the register port between phases, with random bubbles on both
// channels except in one back-to-back phase.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sed_pkg::*;

   localparam int QUIET_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 8;
   localparam word_type Q_ONE = 32'h0001_0000;
   localparam word_type W_MAX = 32'h7fff_ffff;
   localparam word_type W_MIN = 32'h8000_0000;

   typedef struct packed {
      vec3_type start_pt;
      vec3_type end_pt;
      vec3_type norm_a;
      vec3_type norm_b;
   } edge_type;

   typedef struct packed {
      word_type   x;
      word_type   y;
      word_type   z;
      corner_type corner;
      logic       last;
   } vertex_type;

   typedef enum {EDGE_OPEN, EDGE_SILHOUETTE} edge_kind_type;
   typedef enum {WORD_FULL, WORD_SMALL, WORD_EXTREME, WORD_MIXED} word_style_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_start_x = '0;
   logic signed [31:0] req_start_y = '0;
   logic signed [31:0] req_start_z = '0;
   logic signed [31:0] req_end_x = '0;
   logic signed [31:0] req_end_y = '0;
   logic signed [31:0] req_end_z = '0;
   logic signed [31:0] req_normal_a_x = '0;
   logic signed [31:0] req_normal_a_y = '0;
   logic signed [31:0] req_normal_a_z = '0;
   logic signed [31:0] req_normal_b_x = '0;
   logic signed [31:0] req_normal_b_y = '0;
   logic signed [31:0] req_normal_b_z = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_vertex_x;
   logic signed [31:0] rsp_vertex_y;
   logic signed [31:0] rsp_vertex_z;
   logic [1:0]         rsp_corner;
   logic               rsp_last_vertex;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   cfg_type    light_cfg = '{LIGHT_X_RESET, LIGHT_Y_RESET, LIGHT_Z_RESET,
                             EXTRUDE_LENGTH_RESET};
   edge_type   pending_edges[$];
   vertex_type expected_vertices[$];
   edge_type   driven_edge;
   vertex_type want;
   logic       req_taken = 1'b0;
   bit         bubbles_on = 1'b1;
   int         gap_left = 0;
   int         stall_left = 0;
   int         quiet_cycles = 0;
   int         failures = 0;
   int         edges_sent = 0;
   int         silhouettes = 0;
   int         vertices_checked = 0;
   int         light_settings = 1;

   silhouette_edge_extrude_core uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic vec3_type light_pos();
      return {light_cfg.light_z, light_cfg.light_y, light_cfg.light_x};
   endfunction

   function automatic logic face_front(input vec3_type pt, input vec3_type normal);
      logic signed [66:0] acc;
      logic signed [66:0] dir;
      logic signed [66:0] nrm;
      vec3_type lp;
      lp = light_pos();
      acc = '0;
      for (int i = 0; i < 3; i++) begin
         dir = $signed(pt[i]) - $signed(lp[i]);
         nrm = $signed(normal[i]);
         acc = acc + dir * nrm;
      end
      return acc > 0;
   endfunction

   function automatic word_type extrude_coord(input word_type p, input word_type l);
      logic signed [66:0] proj;
      logic signed [66:0] scaled;
      word_type r;
      proj = $signed(p) - $signed(l);
      scaled = (proj * $signed({36'd0, light_cfg.extrude_length})) >>> 16;
      scaled = scaled + $signed(p);
      if (scaled > SAT_HI) begin
         r = W_MAX;
      end else if (scaled < SAT_LO) begin
         r = W_MIN;
      end else begin
         r = scaled[31:0];
      end
      return r;
   endfunction

   function automatic void queue_vertex(input vec3_type v, input corner_type c);
      vertex_type vx;
      vx.x = v[0];
      vx.y = v[1];
      vx.z = v[2];
      vx.corner = c;
      vx.last = (c == CORNER_EXT_START);
      expected_vertices = {expected_vertices, vx};
   endfunction

   function automatic void append_edge(input edge_type item);
      pending_edges = {pending_edges, item};
   endfunction

   function automatic void predict_quad(input edge_type item);
      vec3_type near_pt;
      vec3_type far_pt;
      vec3_type near_ext;
      vec3_type far_ext;
      vec3_type lp;
      logic front_a;
      logic front_b;
      front_a = face_front(item.start_pt, item.norm_a);
      front_b = face_front(item.start_pt, item.norm_b);
      if (front_a != front_b) begin
         near_pt = front_a ? item.start_pt : item.end_pt;
         far_pt = front_a ? item.end_pt : item.start_pt;
         lp = light_pos();
         for (int i = 0; i < 3; i++) begin
            near_ext[i] = extrude_coord(near_pt[i], lp[i]);
            far_ext[i] = extrude_coord(far_pt[i], lp[i]);
         end
         silhouettes++;
         queue_vertex(near_pt, CORNER_START);
         queue_vertex(far_pt, CORNER_END);
         queue_vertex(far_ext, CORNER_EXT_END);
         queue_vertex(near_ext, CORNER_EXT_START);
      end
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic word_type pick_word(input word_style_type style);
      word_style_type s;
      word_type w;
      s = style;
      if (s == WORD_MIXED) s = word_style_type'($urandom_range(0, 2));
      case (s)
         WORD_SMALL: begin
            w = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
         end
         WORD_EXTREME: begin
            case ($urandom_range(0, 5))
               0: w = W_MIN;
               1: w = W_MAX;
               2: w = '0;
               3: w = '1;
               4: w = 32'd1;
               default: w = W_MIN + 32'd1;
            endcase
         end
         default: begin
            w = $urandom;
         end
      endcase
      return w;
   endfunction

   function automatic vec3_type pick_vec3(input word_style_type style);
      return {pick_word(style), pick_word(style), pick_word(style)};
   endfunction

   function automatic vec3_type flip(input vec3_type v);
      return {-v[2], -v[1], -v[0]};
   endfunction

   function automatic edge_type make_edge(input edge_kind_type kind,
                                          input word_style_type style);
      edge_type item;
      vec3_type held;
      item.start_pt = pick_vec3(style);
      item.end_pt = pick_vec3(style);
      item.norm_a = pick_vec3(style);
      item.norm_b = pick_vec3(style);
      if (kind == EDGE_SILHOUETTE) begin
         if (!face_front(item.start_pt, item.norm_a)) item.norm_a = flip(item.norm_a);
         if (face_front(item.start_pt, item.norm_b)) item.norm_b = flip(item.norm_b);
         if ($urandom_range(0, 1) == 1) begin
            held = item.norm_a;
            item.norm_a = item.norm_b;
            item.norm_b = held;
         end
      end
      return item;
   endfunction

   function automatic edge_type random_edge();
      int roll;
      word_style_type style;
      roll = $urandom_range(0, 9);
      if (roll < 2) return make_edge(EDGE_OPEN, WORD_MIXED);
      case ($urandom_range(0, 9))
         0: style = WORD_EXTREME;
         1: style = WORD_FULL;
         default: style = WORD_SMALL;
      endcase
      return make_edge(roll < 5 ? EDGE_OPEN : EDGE_SILHOUETTE, style);
   endfunction

   function automatic vec3_type v3(input word_type x, input word_type y, input word_type z);
      return {z, y, x};
   endfunction

   function automatic void queue_edge(input vec3_type s, input vec3_type e,
                                      input vec3_type a, input vec3_type b);
      edge_type item;
      item.start_pt = s;
      item.end_pt = e;
      item.norm_a = a;
      item.norm_b = b;
      append_edge(item);
   endfunction

   task automatic csr_write(input reg_index_type idx, input word_type value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_LIGHT_X: light_cfg.light_x = value;
         REG_LIGHT_Y: light_cfg.light_y = value;
         REG_LIGHT_Z: light_cfg.light_z = value;
         REG_EXTRUDE_LENGTH: light_cfg.extrude_length = value[30:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic settle();
      @(posedge clock);
      while (pending_edges.size() != 0 || req_valid || expected_vertices.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input word_type lx, input word_type ly, input word_type lz,
                            input word_type len, input int count, input bit bubbles);
      csr_write(REG_LIGHT_X, lx);
      csr_write(REG_LIGHT_Y, ly);
      csr_write(REG_LIGHT_Z, lz);
      csr_write(REG_EXTRUDE_LENGTH, len);
      light_settings++;
      bubbles_on = bubbles;
      for (int n = 0; n < count; n++) append_edge(random_edge());
      settle();
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_edges.size() > 0) begin
            driven_edge = pending_edges.pop_front();
            req_valid <= 1'b1;
            req_start_x <= driven_edge.start_pt[0];
            req_start_y <= driven_edge.start_pt[1];
            req_start_z <= driven_edge.start_pt[2];
            req_end_x <= driven_edge.end_pt[0];
            req_end_y <= driven_edge.end_pt[1];
            req_end_z <= driven_edge.end_pt[2];
            req_normal_a_x <= driven_edge.norm_a[0];
            req_normal_a_y <= driven_edge.norm_a[1];
            req_normal_a_z <= driven_edge.norm_a[2];
            req_normal_b_x <= driven_edge.norm_b[0];
            req_normal_b_y <= driven_edge.norm_b[1];
            req_normal_b_z <= driven_edge.norm_b[2];
            gap_left = bubbles_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (bubbles_on && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_vertices.size() == 0) begin
            $error("vertex transfer with no quad pending: x %0d y %0d z %0d corner %0d",
                   rsp_vertex_x, rsp_vertex_y, rsp_vertex_z, rsp_corner);
            failures++;
         end else begin
            want = expected_vertices.pop_front();
            vertices_checked++;
            if (rsp_vertex_x !== want.x) begin
               $error("vertex_x: expected %0d, actual %0d", $signed(want.x), rsp_vertex_x);
               failures++;
            end
            if (rsp_vertex_y !== want.y) begin
               $error("vertex_y: expected %0d, actual %0d", $signed(want.y), rsp_vertex_y);
               failures++;
            end
            if (rsp_vertex_z !== want.z) begin
               $error("vertex_z: expected %0d, actual %0d", $signed(want.z), rsp_vertex_z);
               failures++;
            end
            if (rsp_corner !== want.corner) begin
               $error("corner: expected %0d, actual %0d", want.corner, rsp_corner);
               failures++;
            end
            if (rsp_last_vertex !== want.last) begin
               $error("last_vertex: expected %0d, actual %0d", want.last, rsp_last_vertex);
               failures++;
            end
         end
      end
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         predict_quad(driven_edge);
         edges_sent++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", quiet_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      vec3_type origin;
      vec3_type tip;
      vec3_type pos_x;
      vec3_type neg_x;
      vec3_type all_max;
      vec3_type all_min;
      origin = v3(0, 0, 0);
      tip = v3(Q_ONE, 2 * Q_ONE, -Q_ONE);
      pos_x = v3(Q_ONE, 0, 0);
      neg_x = v3(-Q_ONE, 0, 0);
      all_max = v3(W_MAX, W_MAX, W_MAX);
      all_min = v3(W_MIN, W_MIN, W_MIN);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_edge(origin, tip, neg_x, pos_x);
      queue_edge(origin, tip, pos_x, neg_x);
      queue_edge(origin, tip, neg_x, neg_x);
      queue_edge(origin, tip, pos_x, pos_x);
      queue_edge(origin, tip, v3(0, 0, Q_ONE), neg_x);
      queue_edge(origin, tip, v3(0, 0, 0), v3(-Q_ONE, -Q_ONE, 0));
      queue_edge(v3(5 * Q_ONE, 5 * Q_ONE, 0), tip, neg_x, pos_x);
      queue_edge(v3(5 * Q_ONE + 1, 5 * Q_ONE, 0), tip, v3(1, 0, 0), v3(-1, 0, 0));
      queue_edge(v3(5 * Q_ONE + 1, 5 * Q_ONE, 0), tip, v3(-1, 0, 0), v3(1, 0, 0));
      queue_edge(v3(5 * Q_ONE + 1, 5 * Q_ONE - 1, 0), tip, v3(1, 1, 0), v3(1, 0, 0));
      queue_edge(all_max, all_max, all_max, all_min);
      queue_edge(all_min, all_min, all_min, all_max);
      queue_edge(all_max, all_min, all_max, all_min);
      queue_edge(all_min, all_max, all_min, all_max);
      for (int n = 0; n < 6; n++) begin
         append_edge(make_edge(EDGE_SILHOUETTE, WORD_EXTREME));
      end
      for (int n = 0; n < 30; n++) append_edge(random_edge());
      settle();

      run_phase(W_MAX, W_MIN, W_MAX, W_MAX, 45, 1'b1);
      run_phase(W_MIN, W_MIN, W_MIN, W_MIN, 45, 1'b1);
      run_phase(pick_word(WORD_SMALL), pick_word(WORD_SMALL), pick_word(WORD_SMALL),
                $urandom_range(0, 32'h0010_0000), 45, 1'b0);
      run_phase($urandom, $urandom, $urandom, $urandom, 45, 1'b1);
      run_phase(0, 0, 0, 32'd1, 45, 1'b1);
      run_phase(LIGHT_X_RESET, LIGHT_Y_RESET, LIGHT_Z_RESET, {1'b0, EXTRUDE_LENGTH_RESET},
                45, 1'b1);

      if (expected_vertices.size() != 0) begin
         $error("%0d expected vertices never arrived", expected_vertices.size());
         failures++;
      end
      $display("Sent %0d edges (%0d silhouettes) under %0d light settings.",
               edges_sent, silhouettes, light_settings);
      $display("Checked %0d vertices, %0d mismatches.", vertices_checked, failures);
      if (failures == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
